// ----- hw/rtl/imu_tilt_init_gyro_integrator_top_assert.svh -----
// Assertion macros for the checker file of the attitude estimator.
`ifndef IMU_TILT_INIT_GYRO_INTEGRATOR_TOP_ASSERT_SVH
`define IMU_TILT_INIT_GYRO_INTEGRATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ITG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itg assertion failed");

// Next-cycle implication.
`define ITG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itg assertion failed");

`endif

// ----- hw/rtl/itg_pkg.sv -----
// Types, constants and tables shared by the attitude estimator modules.
`default_nettype none
package itg_pkg;

	localparam int CAL_SAMPLES_DEF = 100;
	localparam int CNT_W = 11;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int CORDIC_STEPS = 25;

	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic [22:0] TWO_PI_Q16 = 23'd411775;

	localparam logic signed [27:0] ATAN_Q24 [CORDIC_STEPS] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
		28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
		28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
		28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4,
		28'sd2, 28'sd1
	};

	typedef enum logic {
		K_ACCEL,
		K_GYRO
	} itg_kind_t;

	typedef struct packed {
		itg_kind_t kind;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic [15:0] delta_t;
	} itg_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_MAG,
		ST_ACC,
		ST_CAL,
		ST_GDIV,
		ST_RLD,
		ST_RDIV,
		ST_RFIN,
		ST_RSQ,
		ST_CSQ,
		ST_PCOR,
		ST_RLOAD,
		ST_RCOR,
		ST_FIN,
		ST_GMUL,
		ST_GRED,
		ST_OUT
	} itg_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/itg_front.sv -----
// Input stage: accepts items, tags their kind and queues them for the back end.
`default_nettype none
module itg_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                func,
	input  wire logic signed [15:0]  accel_x,
	input  wire logic signed [15:0]  accel_y,
	input  wire logic signed [15:0]  accel_z,
	input  wire logic signed [15:0]  rate_x,
	input  wire logic signed [15:0]  rate_y,
	input  wire logic signed [15:0]  rate_z,
	input  wire logic [15:0]         delta_t,
	output itg_pkg::itg_item_t       item,
	input  wire logic                q_pop,
	output logic                     q_vld
);
	import itg_pkg::*;

	itg_item_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0] cnt_q;
	logic push, pop;
	itg_item_t in_item;

	always_comb begin
		in_item.kind = func ? K_GYRO : K_ACCEL;
		in_item.accel_x = accel_x;
		in_item.accel_y = accel_y;
		in_item.accel_z = accel_z;
		in_item.rate_x = rate_x;
		in_item.rate_y = rate_y;
		in_item.rate_z = rate_z;
		in_item.delta_t = delta_t;
	end

	assign in_stall = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_vld = (cnt_q != '0);
	assign pop = q_pop && q_vld;
	assign item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/itg_back.sv -----
// Execution stage: calibration sums, sqrt, divider, CORDIC and gyro integration.
`default_nettype none
module itg_back #(
	parameter int CAL_SAMPLES = itg_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  itg_pkg::itg_item_t       item,
	input  wire logic                q_vld,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [19:0]       roll_angle,
	output logic signed [19:0]       pitch_angle,
	output logic signed [19:0]       yaw_angle,
	output logic [15:0]              gravity_level,
	output logic                     calibrated
);
	import itg_pkg::*;

	// Gravity is the magnitude sum times a rounded-up reciprocal of the sample count.
	// With a 26-bit sum and this shift the truncated product equals the exact quotient.
	localparam int GRAV_SH = 26 + $clog2(CAL_SAMPLES);
	localparam logic [31:0] GRAV_RECIP = 32'(((64'd1 << GRAV_SH) + 64'(CAL_SAMPLES)
		- 64'd1) / 64'(CAL_SAMPLES));

	itg_state_t state_q, state_d;

	logic signed [26:0] sum_x_q, sum_y_q, sum_z_q;
	logic [25:0] sum_mag_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [19:0] roll_q, pitch_q, yaw_q;
	logic [15:0] grav_q;
	logic done_q;
	itg_item_t cur_q;
	logic [1:0] idx_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;
	logic [31:0] sq_q;

	logic [61:0] sv_q, sres_q, sbit_q;
	logic [62:0] s_trial;
	logic s_ge;

	logic [55:0] dn_q, dq_q;
	logic [25:0] drem_q, dd_q;
	logic [5:0] dcnt_q;
	logic [26:0] d_shift;
	logic d_ge;

	logic signed [31:0] r_q;
	logic [30:0] r_mag;

	logic signed [59:0] cx_q, cy_q, cxs, cys;
	logic signed [27:0] cz_q, cz_rnd;
	logic [4:0] ci_q;

	logic signed [26:0] z_abs, y_fold;
	logic signed [26:0] x_abs;
	logic signed [33:0] g_prod, g_rnd;
	logic signed [21:0] g_step;
	logic signed [19:0] g_ang;
	logic signed [22:0] g_diff;
	logic [22:0] g_mag, g_red;
	logic signed [19:0] g_res;

	logic out_load;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_vld) begin
					if (item.kind == K_ACCEL && !done_q) begin
						state_d = ST_SQ;
					end else if (item.kind == K_GYRO && done_q) begin
						state_d = ST_GMUL;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SQ: if (idx_q == 2'd3) state_d = ST_MAG;
			ST_MAG: if (sbit_q == '0) state_d = ST_ACC;
			ST_ACC: begin
				if (cnt_q + 1'b1 >= CNT_W'(CAL_SAMPLES)) begin
					state_d = ST_CAL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_CAL: state_d = ST_GDIV;
			ST_GDIV: state_d = ST_RLD;
			ST_RLD: state_d = ST_RDIV;
			ST_RDIV: if (dcnt_q == 6'd55) state_d = ST_RFIN;
			ST_RFIN: state_d = ST_RSQ;
			ST_RSQ: if (idx_q == 2'd1) state_d = ST_CSQ;
			ST_CSQ: if (sbit_q == '0) state_d = ST_PCOR;
			ST_PCOR: if (ci_q == 5'(CORDIC_STEPS - 1)) state_d = ST_RLOAD;
			ST_RLOAD: begin
				if (sum_z_q == '0) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_RCOR;
				end
			end
			ST_RCOR: if (ci_q == 5'(CORDIC_STEPS - 1)) state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_GMUL: state_d = ST_GRED;
			ST_GRED: begin
				if (idx_q == 2'd2) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_GMUL;
				end
			end
			ST_OUT: if (!out_valid || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs and multiplier operand selection.
	always_comb begin
		q_pop = 1'b0;
		out_load = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_IDLE: q_pop = q_vld;
			ST_SQ: begin
				case (idx_q)
					2'd0: mul_a = {{16{cur_q.accel_x[15]}}, cur_q.accel_x};
					2'd1: mul_a = {{16{cur_q.accel_y[15]}}, cur_q.accel_y};
					2'd2: mul_a = {{16{cur_q.accel_z[15]}}, cur_q.accel_z};
					default: mul_a = '0;
				endcase
				mul_b = mul_a;
			end
			ST_CAL: begin
				mul_a = {6'b0, sum_mag_q};
				mul_b = GRAV_RECIP;
			end
			ST_RSQ: begin
				mul_a = r_q;
				mul_b = r_q;
			end
			ST_GMUL: begin
				case (idx_q)
					2'd0: mul_a = {{16{cur_q.rate_y[15]}}, cur_q.rate_y};
					2'd1: mul_a = {{16{cur_q.rate_z[15]}}, cur_q.rate_z};
					default: mul_a = {{16{cur_q.rate_x[15]}}, cur_q.rate_x};
				endcase
				mul_b = {16'b0, cur_q.delta_t};
			end
			ST_OUT: out_load = !out_valid || !out_stall;
			default: begin
			end
		endcase
	end

	// Shared datapath pieces.
	always_comb begin
		s_trial = {1'b0, sres_q} + {1'b0, sbit_q};
		s_ge = ({1'b0, sv_q} >= s_trial);

		d_shift = {drem_q, dn_q[55]};
		d_ge = (d_shift >= {1'b0, dd_q});

		cxs = cx_q >>> ci_q;
		cys = cy_q >>> ci_q;
		cz_rnd = cz_q + 28'sd128;

		x_abs = sum_x_q[26] ? -sum_x_q : sum_x_q;
		z_abs = sum_z_q[26] ? -sum_z_q : sum_z_q;
		y_fold = sum_z_q[26] ? -sum_y_q : sum_y_q;
		r_mag = (dq_q > 56'd1073741824) ? 31'd1073741824 : dq_q[30:0];

		case (idx_q)
			2'd0: g_ang = pitch_q;
			2'd1: g_ang = roll_q;
			default: g_ang = yaw_q;
		endcase
		g_prod = prod_q[33:0];
		g_rnd = g_prod + 34'sd2048;
		g_step = g_rnd[33:12];
		g_diff = {{3{g_ang[19]}}, g_ang} - {g_step[21], g_step};
		g_mag = g_diff[22] ? 23'(-g_diff) : 23'(g_diff);
		// The difference stays below three turns, so two trial subtractions suffice.
		if (g_mag >= {TWO_PI_Q16[21:0], 1'b0}) begin
			g_red = g_mag - {TWO_PI_Q16[21:0], 1'b0};
		end else if (g_mag >= TWO_PI_Q16) begin
			g_red = g_mag - TWO_PI_Q16;
		end else begin
			g_red = g_mag;
		end
		g_res = g_diff[22] ? -20'(g_red) : 20'(g_red);
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (q_pop) begin
			cur_q <= item;
		end

		unique case (state_q) inside
			ST_SQ: begin
				case (idx_q)
					2'd1: sq_q <= prod_q[31:0];
					2'd2: sq_q <= sq_q + prod_q[31:0];
					2'd3: begin
						sv_q <= {30'b0, sq_q + prod_q[31:0]};
						sres_q <= '0;
						sbit_q <= 62'd1 << 60;
					end
					default: begin
					end
				endcase
			end
			ST_MAG, ST_CSQ: begin
				if (sbit_q != '0) begin
					if (s_ge) begin
						sv_q <= sv_q - s_trial[61:0];
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end else if (state_q == ST_CSQ) begin
					cx_q <= {28'b0, sres_q[31:0]};
					cy_q <= -{{28{r_q[31]}}, r_q};
					cz_q <= '0;
					ci_q <= '0;
				end
			end
			ST_RDIV: begin
				drem_q <= d_ge ? 26'(d_shift - {1'b0, dd_q}) : d_shift[25:0];
				dn_q <= dn_q << 1;
				dq_q <= {dq_q[54:0], d_ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_RLD: begin
				dn_q <= {x_abs[25:0], 30'b0};
				dd_q <= sum_mag_q;
				drem_q <= '0;
				dcnt_q <= '0;
			end
			ST_RFIN: begin
				if (sum_mag_q == '0) begin
					r_q <= '0;
				end else if (sum_x_q[26]) begin
					r_q <= -{1'b0, r_mag};
				end else begin
					r_q <= {1'b0, r_mag};
				end
			end
			ST_RSQ: begin
				if (idx_q == 2'd1) begin
					sv_q <= (62'd1 << 60) - prod_q[61:0];
					sres_q <= '0;
					sbit_q <= 62'd1 << 60;
				end
			end
			ST_PCOR, ST_RCOR: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + cys;
					cy_q <= cy_q - cxs;
					cz_q <= cz_q + ATAN_Q24[ci_q];
				end else begin
					cx_q <= cx_q - cys;
					cy_q <= cy_q + cxs;
					cz_q <= cz_q - ATAN_Q24[ci_q];
				end
				ci_q <= ci_q + 1'b1;
			end
			ST_RLOAD: begin
				cx_q <= {{3{z_abs[26]}}, z_abs, 30'b0};
				cy_q <= {{3{y_fold[26]}}, y_fold, 30'b0};
				cz_q <= '0;
				ci_q <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			sum_mag_q <= '0;
			cnt_q <= '0;
			roll_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
			grav_q <= '0;
			done_q <= 1'b0;
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q) inside
				ST_IDLE, ST_RFIN: idx_q <= '0;
				ST_SQ, ST_RSQ: idx_q <= idx_q + 1'b1;
				ST_GRED: begin
					idx_q <= idx_q + 1'b1;
					case (idx_q)
						2'd0: pitch_q <= g_res;
						2'd1: roll_q <= g_res;
						default: yaw_q <= g_res;
					endcase
				end
				ST_ACC: begin
					sum_x_q <= sum_x_q + {{11{cur_q.accel_x[15]}}, cur_q.accel_x};
					sum_y_q <= sum_y_q - {{11{cur_q.accel_y[15]}}, cur_q.accel_y};
					sum_z_q <= sum_z_q + {{11{cur_q.accel_z[15]}}, cur_q.accel_z};
					sum_mag_q <= sum_mag_q + 26'(sres_q);
					cnt_q <= cnt_q + 1'b1;
				end
				ST_GDIV: grav_q <= prod_q[GRAV_SH +: 16];
				ST_RLOAD: begin
					pitch_q <= cz_rnd[27:8];
					if (sum_z_q == '0) begin
						if (sum_y_q > 0) begin
							roll_q <= HALF_PI_Q16;
						end else if (sum_y_q < 0) begin
							roll_q <= -HALF_PI_Q16;
						end else begin
							roll_q <= '0;
						end
						yaw_q <= '0;
						done_q <= 1'b1;
					end
				end
				ST_FIN: begin
					roll_q <= cz_rnd[27:8];
					yaw_q <= '0;
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase

			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			roll_angle <= roll_q;
			pitch_angle <= pitch_q;
			yaw_angle <= yaw_q;
			gravity_level <= grav_q;
			calibrated <= done_q;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/imu_tilt_init_gyro_integrator_top.sv -----
// The back end takes one transaction at a time, through the shared square root (31 steps),
// the restoring divider (56 steps) and the 25-step CORDIC.
// A two-entry queue lets new transactions arrive while the back end works.
// Reset clears all sums, angles, gravity and the calibrated flag; nothing else is needed.
`default_nettype none
module imu_tilt_init_gyro_integrator_top #(
	parameter int CAL_SAMPLES = itg_pkg::CAL_SAMPLES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                func,
	input  wire logic signed [15:0]  accel_x,
	input  wire logic signed [15:0]  accel_y,
	input  wire logic signed [15:0]  accel_z,
	input  wire logic signed [15:0]  rate_x,
	input  wire logic signed [15:0]  rate_y,
	input  wire logic signed [15:0]  rate_z,
	input  wire logic [15:0]         delta_t,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [19:0]       roll_angle,
	output logic signed [19:0]       pitch_angle,
	output logic signed [19:0]       yaw_angle,
	output logic [15:0]              gravity_level,
	output logic                     calibrated
);
	import itg_pkg::*;

	itg_item_t item;
	logic q_vld;
	logic q_pop;

	itg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.rate_x   (rate_x),
		.rate_y   (rate_y),
		.rate_z   (rate_z),
		.delta_t  (delta_t),
		.item     (item),
		.q_pop    (q_pop),
		.q_vld    (q_vld)
	);

	itg_back #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.q_vld         (q_vld),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.roll_angle    (roll_angle),
		.pitch_angle   (pitch_angle),
		.yaw_angle     (yaw_angle),
		.gravity_level (gravity_level),
		.calibrated    (calibrated)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/itg_checker.sv -----
// Port-level checker for the attitude estimator and its bind to the top level.
`default_nettype none
`include "imu_tilt_init_gyro_integrator_top_assert.svh"
module itg_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic signed [19:0]  roll_angle,
	input  wire logic signed [19:0]  pitch_angle,
	input  wire logic signed [19:0]  yaw_angle,
	input  wire logic [15:0]         gravity_level,
	input  wire logic                calibrated
);
	logic seen_cal_q;
	logic [36:0] held_view;
	logic all_zero;
	logic angles_ok;

	// Remembers that a calibrated result has been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cal_q <= 1'b0;
		end else if (out_valid && !out_stall && calibrated) begin
			seen_cal_q <= 1'b1;
		end
	end

	always_comb begin
		held_view = {calibrated, gravity_level, pitch_angle};
		all_zero = (roll_angle == 0) && (pitch_angle == 0) && (yaw_angle == 0)
			&& (gravity_level == 0);
		angles_ok = (pitch_angle < 20'sd411775) && (pitch_angle > -20'sd411775)
			&& (roll_angle < 20'sd411775) && (roll_angle > -20'sd411775)
			&& (yaw_angle < 20'sd411775) && (yaw_angle > -20'sd411775);
	end

	`ITG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(held_view))
	`ITG_ASSERT_IMP(a_precal_zero, out_valid && !calibrated, all_zero)
	`ITG_ASSERT_IMP(a_cal_sticky, out_valid && seen_cal_q, calibrated)
	`ITG_ASSERT_IMP(a_angle_range, out_valid, angles_ok)

endmodule

bind imu_tilt_init_gyro_integrator_top itg_checker u_itg_checker (.*);
`default_nettype wire
